### src/strict_priority_three_queues_defines.svh
// Assertion macros shared by the queue controller and datapath
`ifndef STRICT_PRIORITY_THREE_QUEUES_DEFINES_SVH
`define STRICT_PRIORITY_THREE_QUEUES_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SPQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define SPQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/spq_pkg.sv
// Shared widths, request codes and controller command type for the priority queues
package spq_pkg;

    localparam int ACTION_W = 2;
    localparam int SEL_W    = 2;
    localparam int TICKET_W = 16;
    localparam int COUNT_W  = 5;
    localparam int TOTAL_W  = 6;

    typedef logic [ACTION_W-1:0] t_action;
    typedef logic [SEL_W-1:0]    t_sel;
    typedef logic [TICKET_W-1:0] t_ticket;
    typedef logic [COUNT_W-1:0]  t_count;
    typedef logic [TOTAL_W-1:0]  t_total;

    localparam t_action ACT_ENQUEUE       = 2'd0;
    localparam t_action ACT_SERVE         = 2'd1;
    localparam t_action ACT_SERVE_HIGHEST = 2'd2;

    typedef struct packed {
        logic load_req;
        logic exec;
        logic load_out;
    } t_cmd;

endpackage

### src/spq_req_if.sv
// Request channel: valid/ready handshake with action, line select and ticket
interface spq_req_if
    import spq_pkg::*;
;
    logic    valid;
    logic    ready;
    t_action action;
    t_sel    line_select;
    t_ticket ticket_in;

    modport source (output valid, output action, output line_select, output ticket_in,
                    input ready);
    modport sink   (input valid, input action, input line_select, input ticket_in,
                    output ready);
endinterface

### src/spq_rsp_if.sv
// Result channel: valid/ready handshake with served ticket, counts and drop flag
interface spq_rsp_if
    import spq_pkg::*;
;
    logic    valid;
    logic    ready;
    t_ticket served_ticket;
    t_count  count_first;
    t_count  count_second;
    t_count  count_third;
    t_total  count_total;
    logic    dropped;

    modport source (output valid, output served_ticket, output count_first,
                    output count_second, output count_third, output count_total,
                    output dropped, input ready);
    modport sink   (input valid, input served_ticket, input count_first,
                    input count_second, input count_third, input count_total,
                    input dropped, output ready);
endinterface

### src/spq_ctrl.sv
// Controller state machine: sequences accept, queue access and result load
`include "strict_priority_three_queues_defines.svh"
module spq_ctrl
    import spq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       in_acc;
    logic       out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    assign o_cmd.load_req = in_acc;
    assign o_cmd.exec     = (r_state == S_EXEC);
    assign o_cmd.load_out = (r_state == S_LOAD) && out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `SPQ_ASSERT_NXT(a_acc_to_exec, i_clk, i_rst_n, in_acc, r_state == S_EXEC, "accept must start access")
    `SPQ_ASSERT_NXT(a_exec_to_load, i_clk, i_rst_n, r_state == S_EXEC, r_state == S_LOAD, "access must be followed by load")
    `SPQ_ASSERT_NXT(a_load_sets_valid, i_clk, i_rst_n, o_cmd.load_out, r_out_valid && r_state == S_IDLE, "load must present a result and free the controller")
    `SPQ_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n, r_out_valid && !i_out_ready, r_out_valid, "stalled result must stay valid")

endmodule

### src/spq_dp.sv
// Datapath: ticket store, per-queue pointers and counts, result registers
`include "strict_priority_three_queues_defines.svh"
module spq_dp
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TICKET_BITS = 16,
    parameter int NUM_QUEUES  = 3
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  t_action i_action,
    input  t_sel    i_line_select,
    input  t_ticket i_ticket_in,
    output t_ticket o_served_ticket,
    output t_count  o_count_first,
    output t_count  o_count_second,
    output t_count  o_count_third,
    output t_total  o_count_total,
    output logic    o_dropped
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int QID_W  = $clog2(NUM_QUEUES);
    localparam int ADDR_W = $clog2(NUM_QUEUES * QUEUE_DEPTH);
    localparam int SUM_W  = CNT_W + 3;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [3:0]       NQ_LIM   = 4'(NUM_QUEUES);

    logic [TICKET_BITS-1:0] r_mem [NUM_QUEUES * QUEUE_DEPTH];
    logic [TICKET_BITS-1:0] r_rdata;

    logic [PTR_W-1:0] r_head  [NUM_QUEUES];
    logic [PTR_W-1:0] r_tail  [NUM_QUEUES];
    logic [CNT_W-1:0] r_count [NUM_QUEUES];

    t_action                r_action;
    t_sel                   r_sel;
    logic [TICKET_BITS-1:0] r_ticket;
    logic                   r_pop;
    logic                   r_drop;

    t_ticket r_served;
    t_count  r_cnt0;
    t_count  r_cnt1;
    t_count  r_cnt2;
    t_total  r_total;
    logic    r_dropped;

    logic             sel_valid;
    logic [QID_W-1:0] sel_q;
    logic             hi_found;
    logic [QID_W-1:0] hi_q;
    logic [QID_W-1:0] tq;
    logic             do_push;
    logic             do_pop;
    logic             drop;
    logic [PTR_W-1:0] ptr;
    logic [ADDR_W-1:0] addr;
    t_count           cnt_pad [3];
    logic [SUM_W-1:0] sum;

    assign sel_valid = ({2'b00, r_sel} < NQ_LIM);
    assign sel_q     = sel_valid ? QID_W'(r_sel) : '0;

    always_comb begin
        hi_found = 1'b0;
        hi_q     = '0;
        for (int q = NUM_QUEUES - 1; q >= 0; q--) begin
            if (r_count[q] != '0) begin
                hi_found = 1'b1;
                hi_q     = QID_W'(q);
            end
        end
    end

    always_comb begin
        tq      = sel_q;
        do_push = 1'b0;
        do_pop  = 1'b0;
        drop    = 1'b0;
        unique case (r_action)
            ACT_ENQUEUE: begin
                do_push = sel_valid && (r_count[sel_q] != CNT_FULL);
                drop    = sel_valid && (r_count[sel_q] == CNT_FULL);
            end
            ACT_SERVE: begin
                do_pop = sel_valid && (r_count[sel_q] != '0);
            end
            ACT_SERVE_HIGHEST: begin
                do_pop = hi_found;
                tq     = hi_q;
            end
            default: begin
                do_pop = 1'b0;
            end
        endcase
        ptr  = do_push ? r_tail[tq] : r_head[tq];
        addr = ADDR_W'(int'(tq) * QUEUE_DEPTH + int'(ptr));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (do_push) begin
                r_mem[addr] <= r_ticket;
            end
            r_rdata <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < NUM_QUEUES; q++) begin
                r_head[q]  <= '0;
                r_tail[q]  <= '0;
                r_count[q] <= '0;
            end
        end else if (i_cmd.exec) begin
            if (do_push) begin
                r_tail[tq]  <= (r_tail[tq] == PTR_LAST) ? '0 : r_tail[tq] + 1'b1;
                r_count[tq] <= r_count[tq] + 1'b1;
            end
            if (do_pop) begin
                r_head[tq]  <= (r_head[tq] == PTR_LAST) ? '0 : r_head[tq] + 1'b1;
                r_count[tq] <= r_count[tq] - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_action <= i_action;
            r_sel    <= i_line_select;
            r_ticket <= TICKET_BITS'(i_ticket_in);
        end
        if (i_cmd.exec) begin
            r_pop  <= do_pop;
            r_drop <= drop;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cnt_pad[k] = '0;
        end
        for (int k = 0; k < NUM_QUEUES && k < 3; k++) begin
            cnt_pad[k] = COUNT_W'(r_count[k]);
        end
        sum = '0;
        for (int q = 0; q < NUM_QUEUES; q++) begin
            sum = sum + SUM_W'(r_count[q]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_served  <= r_pop ? TICKET_W'(r_rdata) : '0;
            r_cnt0    <= cnt_pad[0];
            r_cnt1    <= cnt_pad[1];
            r_cnt2    <= cnt_pad[2];
            r_total   <= TOTAL_W'(sum);
            r_dropped <= r_drop;
        end
    end

    assign o_served_ticket = r_served;
    assign o_count_first   = r_cnt0;
    assign o_count_second  = r_cnt1;
    assign o_count_third   = r_cnt2;
    assign o_count_total   = r_total;
    assign o_dropped       = r_dropped;

    `SPQ_ASSERT_IMP(a_push_pop_excl, i_clk, i_rst_n, i_cmd.exec, !(do_push && do_pop) && !(drop && (do_push || do_pop)), "one queue operation per request")
    `SPQ_ASSERT_NXT(a_enq_no_pop, i_clk, i_rst_n, i_cmd.exec && r_action == ACT_ENQUEUE, !r_pop, "enqueue must not serve")
    `SPQ_ASSERT_NXT(a_drop_only_enq, i_clk, i_rst_n, i_cmd.exec && r_action != ACT_ENQUEUE, !r_drop, "only enqueue may drop")

endmodule

### src/strict_priority_three_queues.sv
// Top level: three strict-priority ticket queues behind request/result channels
//
//   channel   dir   fields
//   i_req     in    action, line_select, ticket_in
//   o_rsp     out   served_ticket, count_first..third, count_total, dropped
//
// Each request runs through accept, one access of the shared ticket
// store port (write on enqueue, registered read on serve), then result load.
// The next request is taken as soon as its result is loaded, while that
// result still waits in the output register; a stalled output holds the
// load step. Synchronous reset empties all queues; the store is not cleared.
module strict_priority_three_queues
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TICKET_BITS = 16,
    parameter int NUM_QUEUES  = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    spq_req_if.sink          i_req,
    spq_rsp_if.source        o_rsp
);

    t_cmd cmd;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    spq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TICKET_BITS (TICKET_BITS),
        .NUM_QUEUES  (NUM_QUEUES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_action        (i_req.action),
        .i_line_select   (i_req.line_select),
        .i_ticket_in     (i_req.ticket_in),
        .o_served_ticket (o_rsp.served_ticket),
        .o_count_first   (o_rsp.count_first),
        .o_count_second  (o_rsp.count_second),
        .o_count_third   (o_rsp.count_third),
        .o_count_total   (o_rsp.count_total),
        .o_dropped       (o_rsp.dropped)
    );

endmodule
